/* design/spim_pkg.sv */
// ----------------------------------------------------------------------------
// spim_pkg: shared types and constants for the SPI register access master
// Command codes, op encoding, frame geometry and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package spim_pkg;

  localparam int DATA_BITS  = 8;
  localparam int CMD_BITS   = 16;
  localparam int FRAME_BITS = CMD_BITS + DATA_BITS;
  localparam int ADDR_BITS  = CMD_BITS - 1;
  localparam int IDX_W      = $clog2(FRAME_BITS + 1);
  localparam int BITPOS_W   = $clog2(DATA_BITS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request command codes on the input channel
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_READ  = 3'd2;
  localparam logic [2:0] CMD_SET   = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_SET   = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  // one classified tick as it travels from front end to engine
  typedef struct packed {
    op_e                   op;
    logic [FRAME_BITS-1:0] frame;
    logic [BITPOS_W-1:0]   bit_pos;
    logic                  miso;
  } item_t;

endpackage

`default_nettype wire

/* design/spim_if.sv */
// ----------------------------------------------------------------------------
// spim_if: request and result channel interfaces
// Valid/ready channels carrying one tick request and one tick result.
// ----------------------------------------------------------------------------
`default_nettype none

interface spim_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [14:0] reg_address;
  logic [7:0]  write_byte;
  logic [2:0]  bit_position;
  logic        miso_level;

  modport source (output valid, cmd, reg_address, write_byte, bit_position, miso_level,
                  input ready);
  modport sink   (input valid, cmd, reg_address, write_byte, bit_position, miso_level,
                  output ready);
endinterface

interface spim_res_if;
  logic       valid;
  logic       ready;
  logic       sclk_level;
  logic       cs_n_level;
  logic       mosi_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;

  modport source (output valid, sclk_level, cs_n_level, mosi_level, busy_res, done_res,
                  read_byte, input ready);
  modport sink   (input valid, sclk_level, cs_n_level, mosi_level, busy_res, done_res,
                  read_byte, output ready);
endinterface

`default_nettype wire

/* design/spim_front.sv */
// ----------------------------------------------------------------------------
// spim_front: request intake and classification
// Decodes the command, builds the initial serial frame and pushes the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spim_front import spim_pkg::*; (
  spim_req_if.sink req_i,
  input  logic     full_i,
  output logic     push_o,
  output item_t    item_o
);

  op_e op;

  always_comb begin
    unique case (req_i.cmd)
      CMD_WRITE: op = OP_WRITE;
      CMD_READ:  op = OP_READ;
      CMD_SET:   op = OP_SET;
      CMD_CLEAR: op = OP_CLEAR;
      CMD_TICK:  op = OP_NONE;
      default:   op = OP_NONE;   // unused codes act as a plain tick
    endcase
  end

  assign req_i.ready = ~full_i;
  assign push_o      = req_i.valid & ~full_i;

  always_comb begin
    item_o.op      = op;
    item_o.bit_pos = req_i.bit_position;
    item_o.miso    = req_i.miso_level;
    // write carries its data byte; reads and RMW start with the read flag set
    if (op == OP_WRITE) begin
      item_o.frame = {1'b0, req_i.reg_address, req_i.write_byte};
    end else begin
      item_o.frame = {1'b1, req_i.reg_address, {DATA_BITS{1'b0}}};
    end
  end

endmodule

`default_nettype wire

/* design/spim_fifo.sv */
// ----------------------------------------------------------------------------
// spim_fifo: short queue between front end and engine
// Two-entry FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spim_fifo import spim_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* design/spim_back.sv */
// ----------------------------------------------------------------------------
// spim_back: serial engine and result register
// Runs one half-period tick per queue entry and registers the pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module spim_back import spim_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       pop_o,
  spim_res_if.source res_o
);

  // engine state
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  half_q, half_d;
  op_e                   op_q, op_d;
  logic [DATA_BITS-1:0]  cap_q, cap_d;
  logic                  rmw_q, rmw_d;
  logic [ADDR_BITS-1:0]  laddr_q, laddr_d;
  logic [BITPOS_W-1:0]   lbit_q, lbit_d;

  // result register
  logic                  out_valid_q;
  logic                  sclk_q, cs_n_q, mosi_q, busy_q, done_q;
  logic                  sclk, cs_n, mosi, busy, done;

  logic                  start, reading, inbit;
  logic [FRAME_BITS-1:0] fr;
  logic [IDX_W-1:0]      idx;
  logic                  half, rmw;
  op_e                   op;
  logic [ADDR_BITS-1:0]  laddr;
  logic [BITPOS_W-1:0]   lbit;
  logic [DATA_BITS-1:0]  rb, bit_mask, mod_byte;

  assign pop_o = valid_i & (~out_valid_q | res_o.ready);
  assign start = (op_q == OP_NONE) & (item_i.op != OP_NONE);

  always_comb begin
    // a new request overrides the idle state on the tick it is accepted
    op    = start ? item_i.op : op_q;
    fr    = start ? item_i.frame : frame_q;
    idx   = start ? '0 : idx_q;
    half  = start ? 1'b0 : half_q;
    rmw   = start ? ((item_i.op == OP_SET) | (item_i.op == OP_CLEAR)) : rmw_q;
    laddr = start ? item_i.frame[FRAME_BITS-2 -: ADDR_BITS] : laddr_q;
    lbit  = start ? item_i.bit_pos : lbit_q;

    reading  = (op == OP_READ) | rmw;
    inbit    = reading & (idx >= IDX_W'(CMD_BITS)) & item_i.miso;
    rb       = fr[DATA_BITS-1:0];
    bit_mask = DATA_BITS'(1) << lbit;
    mod_byte = (op == OP_SET) ? (rb | bit_mask) : (rb & ~bit_mask);

    frame_d = fr;
    idx_d   = idx;
    half_d  = half;
    op_d    = op;
    cap_d   = cap_q;
    rmw_d   = rmw;
    laddr_d = laddr;
    lbit_d  = lbit;

    sclk = 1'b0;
    cs_n = 1'b1;
    mosi = 1'b0;
    busy = 1'b0;
    done = 1'b0;

    if (op != OP_NONE) begin
      if (idx < IDX_W'(FRAME_BITS)) begin
        cs_n = 1'b0;
        busy = 1'b1;
        mosi = fr[FRAME_BITS-1];
        if (!half) begin
          half_d = 1'b1;
        end else begin
          sclk    = 1'b1;
          frame_d = {fr[FRAME_BITS-2:0], inbit};
          idx_d   = idx + 1'b1;
          half_d  = 1'b0;
        end
      end else begin
        // chip select high tick closing a frame
        if (reading) begin
          cap_d = rb;
        end
        idx_d  = '0;
        half_d = 1'b0;
        if (rmw) begin
          frame_d = {1'b0, laddr, mod_byte};
          rmw_d   = 1'b0;
          busy    = 1'b1;
        end else begin
          done = 1'b1;
          op_d = OP_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      idx_q       <= '0;
      half_q      <= 1'b0;
      op_q        <= OP_NONE;
      cap_q       <= '0;
      rmw_q       <= 1'b0;
      laddr_q     <= '0;
      lbit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        frame_q <= frame_d;
        idx_q   <= idx_d;
        half_q  <= half_d;
        op_q    <= op_d;
        cap_q   <= cap_d;
        rmw_q   <= rmw_d;
        laddr_q <= laddr_d;
        lbit_q  <= lbit_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sclk_q <= sclk;
      cs_n_q <= cs_n;
      mosi_q <= mosi;
      busy_q <= busy;
      done_q <= done;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.sclk_level = sclk_q;
  assign res_o.cs_n_level = cs_n_q;
  assign res_o.mosi_level = mosi_q;
  assign res_o.busy_res   = busy_q;
  assign res_o.done_res   = done_q;
  assign res_o.read_byte  = cap_q;

endmodule

`default_nettype wire

/* design/spi_register_access_master.sv */
// A tick request's result is registered: an accepted request waits in the queue
//   until the engine pops it, which loads the result register.
// Throughput: one tick request per cycle while the result channel takes each result.
// Reset: asynchronous, active low; engine idle, read byte zero,
//   queue and result register empty.
// ----------------------------------------------------------------------------
// spi_register_access_master: SPI mode-0 register access master, top level
// Tick-driven master for 15-bit address register write, read and bit RMW.
// ----------------------------------------------------------------------------
`default_nettype none

// Each accepted request is one serial half-period tick and yields exactly one
// result with the pin levels for that tick.
//
// Front end: classifies the command (unused codes count as a plain tick) and
// prebuilds the frame: {0, addr, data} for a write, {1, addr, 0} for a read.
// Queue: two entries, lets the engine stall on the result side while the
// front keeps accepting.
// Engine: shifts the 24-bit frame MSB first, low tick drives MOSI, high tick
// raises SCLK and samples MISO into the data byte of a read. After each frame
// one chip-select-high tick ends it; for a read-modify-write that tick also
// patches the selected bit and reloads the write frame.
// Requests arriving while a transaction runs are taken as ticks only.

module spi_register_access_master import spim_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  spim_req_if.sink   req_i,
  spim_res_if.source res_o
);

  logic  push, full, pop, q_valid;
  item_t push_item, pop_item;

  spim_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  spim_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  spim_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (pop_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire
